@@ rtl/vgts_pkg.sv @@
// Shared types and constants of the voltage gate table step unit.
// Used by the controller, the datapath and the top level; no dependencies.
package vgts_pkg;

    localparam int GATE_W     = 18;
    localparam int VOLT_W     = 16;
    localparam int INDEX_W    = 8;
    localparam int MODE_W     = 2;
    localparam int SHIFT_W    = 4;
    localparam int POWER_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS  = GATE_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEADY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VMIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER = 2'd2;

    localparam logic signed [VOLT_W-1:0] VMIN_RESET  = -16'sd128;
    localparam logic [SHIFT_W-1:0]       SHIFT_RESET = 4'd0;
    localparam logic [POWER_W-1:0]       POWER_RESET = 3'd1;

    localparam logic signed [GATE_W-1:0] GATE_MAX = 18'sh1FFFF;
    localparam logic signed [GATE_W-1:0] GATE_MIN = -18'sh20000;

    typedef logic signed [GATE_W-1:0] gate_t;

    typedef struct packed {
        logic capture;
        logic ram_read;
        logic ram_write;
        logic mul_step;
        logic mul_pow;
        logic p_from_acc;
        logic p_from_div;
        logic r_from_prod;
        logic pw_from_r;
        logic div_load;
        logic div_check;
        logic div_iter;
        logic out_load;
        logic out_err;
    } vgts_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              write_ok;
        logic              range_ok;
        logic              den_zero;
        logic [1:0]        pow_count;
    } vgts_stat_t;

endpackage

@@ rtl/vgts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vgts_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/vgts_ctrl.sv @@
// Controller state machine of the voltage gate table step unit.
// Depends on vgts_pkg; drives datapath commands from datapath status.
module vgts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  vgts_pkg::vgts_stat_t stat,
    output vgts_pkg::vgts_cmd_t  cmd
);
    import vgts_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INDEX = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_PMUL  = 4'd4;
    localparam logic [3:0] S_PACC  = 4'd5;
    localparam logic [3:0] S_PEND  = 4'd6;
    localparam logic [3:0] S_DEN   = 4'd7;
    localparam logic [3:0] S_DCHK  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DEND  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        pcnt_reg, pcnt_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              err_reg, err_next;
    logic              mvalid_reg, mvalid_next;

    always_comb
    begin
        state_next  = state_reg;
        pcnt_next   = pcnt_reg;
        dcnt_next   = dcnt_reg;
        err_next    = err_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        cmd.out_err = err_reg;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    err_next    = 1'b0;
                    state_next  = S_INDEX;
                end
            end
            S_INDEX:
            begin
                case (stat.mode)
                    MODE_STEP:
                    begin
                        cmd.ram_read = 1'b1;
                        state_next   = S_MUL;
                    end
                    MODE_WRITE:
                    begin
                        cmd.ram_write = stat.write_ok;
                        state_next    = S_OUT;
                    end
                    MODE_STEADY:
                    begin
                        if (stat.range_ok)
                        begin
                            cmd.ram_read = 1'b1;
                            state_next   = S_DEN;
                        end
                        else
                        begin
                            err_next   = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.p_from_acc = 1'b1;
                pcnt_next      = stat.pow_count;
                state_next     = (stat.pow_count == 2'd0) ? S_PEND : S_PMUL;
            end
            S_PMUL:
            begin
                cmd.mul_pow = 1'b1;
                state_next  = S_PACC;
            end
            S_PACC:
            begin
                cmd.r_from_prod = 1'b1;
                if (pcnt_reg == 2'd1)
                begin
                    state_next = S_PEND;
                end
                else
                begin
                    pcnt_next  = pcnt_reg - 2'd1;
                    state_next = S_PMUL;
                end
            end
            S_PEND:
            begin
                cmd.pw_from_r = 1'b1;
                state_next    = S_OUT;
            end
            S_DEN:
            begin
                if (stat.den_zero)
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DCHK;
                end
            end
            S_DCHK:
            begin
                cmd.div_check = 1'b1;
                dcnt_next     = DCNT_W'(DIV_STEPS - 1);
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_iter = 1'b1;
                if (dcnt_reg == '0)
                begin
                    state_next = S_DEND;
                end
                else
                begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            S_DEND:
            begin
                cmd.p_from_div = 1'b1;
                pcnt_next      = stat.pow_count;
                state_next     = (stat.pow_count == 2'd0) ? S_PEND : S_PMUL;
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pcnt_reg   <= '0;
            dcnt_reg   <= '0;
            err_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pcnt_reg   <= pcnt_next;
            dcnt_reg   <= dcnt_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

@@ rtl/vgts_datapath.sv @@
// Datapath of the voltage gate table step unit: config registers, bin index,
// coefficient RAM, shared multiplier, rounding, divider and output register.
// Depends on vgts_pkg and vgts_ram.
module vgts_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vgts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vgts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [vgts_pkg::MODE_W-1:0]          mode,
    input  logic signed [vgts_pkg::VOLT_W-1:0]   voltage,
    input  logic [vgts_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [vgts_pkg::GATE_W-1:0]   entry_decay,
    input  logic signed [vgts_pkg::GATE_W-1:0]   entry_drive,
    input  vgts_pkg::vgts_cmd_t                  cmd,
    output vgts_pkg::vgts_stat_t                 stat,
    output logic signed [vgts_pkg::GATE_W-1:0]   gate_state,
    output logic signed [vgts_pkg::GATE_W-1:0]   gate_output,
    output logic                                 error
);
    import vgts_pkg::*;

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int AXW  = (IW > INDEX_W) ? IW : INDEX_W;
    localparam int TW   = IW + VOLT_W;
    localparam int BW   = VOLT_W + 2;
    localparam int PW   = 2 * GATE_W;
    localparam int AW   = (FRAC_BITS + 21 > PW + 1) ? FRAC_BITS + 21 : PW + 1;
    localparam int DIVW = FRAC_BITS + 40;

    localparam logic signed [AW-1:0]   HALF_LSB = AW'(1) << (FRAC_BITS - 1);
    localparam logic signed [AW-1:0]   SAT_HI   = AW'(GATE_MAX);
    localparam logic signed [AW-1:0]   SAT_LO   = AW'(GATE_MIN);
    localparam logic signed [DIVW-1:0] ONE_W    = DIVW'(1) << FRAC_BITS;
    localparam logic signed [GATE_W:0] Q_HI     = (GATE_W + 1)'(GATE_MAX);
    localparam logic signed [GATE_W:0] Q_LO     = (GATE_W + 1)'(GATE_MIN);

    function automatic gate_t round_sat(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        y = (x + HALF_LSB) >>> FRAC_BITS;
        if (y > SAT_HI)
        begin
            return GATE_MAX;
        end
        else if (y < SAT_LO)
        begin
            return GATE_MIN;
        end
        return y[GATE_W-1:0];
    endfunction

    // configuration
    logic signed [VOLT_W-1:0] vmin_reg;
    logic [SHIFT_W-1:0]       shift_reg;
    logic [POWER_W-1:0]       power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmin_reg  <= VMIN_RESET;
            shift_reg <= SHIFT_RESET;
            power_reg <= POWER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VMIN:  vmin_reg  <= cfg_data;
                CFG_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_POWER: power_reg <= cfg_data[POWER_W-1:0];
                default:   ;
            endcase
        end
    end

    // captured word
    logic [MODE_W-1:0]         mode_reg;
    logic signed [VOLT_W-1:0]  volt_reg;
    logic [INDEX_W-1:0]        ei_reg;
    gate_t                     c1in_reg;
    gate_t                     c2in_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            volt_reg <= voltage;
            ei_reg   <= entry_index;
            c1in_reg <= entry_decay;
            c2in_reg <= entry_drive;
        end
    end

    // bin index
    logic signed [VOLT_W:0] vdiff;
    logic [BW-1:0]          half;
    logic [BW-1:0]          binned;
    logic [IW-1:0]          idx;
    logic [TW-1:0]          top;
    logic [AXW-1:0]         ei_ext;

    assign vdiff  = {volt_reg[VOLT_W-1], volt_reg} - {vmin_reg[VOLT_W-1], vmin_reg};
    assign half   = (shift_reg == '0) ? '0 : (BW'(1) << (shift_reg - 4'd1));
    assign binned = (BW'({1'b0, vdiff[VOLT_W-1:0]}) + half) >> shift_reg;
    assign top    = TW'(TABLE_DEPTH - 1) << shift_reg;
    assign ei_ext = AXW'(ei_reg);

    always_comb
    begin
        if (vdiff[VOLT_W])
        begin
            idx = '0;
        end
        else if (binned > BW'(TABLE_DEPTH - 1))
        begin
            idx = IW'(TABLE_DEPTH - 1);
        end
        else
        begin
            idx = binned[IW-1:0];
        end
    end

    // coefficient table: drive in the high half, decay in the low half
    logic [PW-1:0] ram_rdata;
    gate_t         tab_c1;
    gate_t         tab_c2;

    vgts_ram #(
        .WIDTH (PW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_write),
        .waddr (ei_ext[IW-1:0]),
        .wdata ({c2in_reg, c1in_reg}),
        .re    (cmd.ram_read),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    assign tab_c1 = ram_rdata[GATE_W-1:0];
    assign tab_c2 = ram_rdata[PW-1:GATE_W];

    // gate state and shared multiplier
    gate_t                p_reg;
    gate_t                pw_reg;
    gate_t                r_reg;
    logic signed [PW-1:0] prod_reg;
    gate_t                mul_a;
    logic signed [AW-1:0] c2_term;
    logic signed [AW-1:0] acc_sum;
    gate_t                rounded;

    assign mul_a   = cmd.mul_step ? tab_c1 : r_reg;
    assign c2_term = cmd.p_from_acc ? (AW'(tab_c2) <<< FRAC_BITS) : AW'(0);
    assign acc_sum = AW'(prod_reg) + c2_term;
    assign rounded = round_sat(acc_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step || cmd.mul_pow)
        begin
            prod_reg <= PW'(mul_a) * PW'(p_reg);
        end
    end

    // steady state divider
    logic signed [DIVW-1:0] c1_w;
    logic signed [DIVW-1:0] den_w;
    logic signed [DIVW-1:0] num_w;
    logic [DIVW-1:0]        an;
    logic [DIVW-1:0]        ad;
    logic [DIVW-1:0]        rem_reg;
    logic [DIVW-1:0]        dsor_reg;
    logic [GATE_W-1:0]      q_reg;
    logic                   neg_reg;
    logic                   ovf_reg;
    logic signed [GATE_W:0] q_ext;
    logic signed [GATE_W:0] q_signed;
    gate_t                  div_value;

    assign c1_w  = DIVW'(tab_c1);
    assign den_w = ONE_W - c1_w;
    assign num_w = DIVW'(tab_c2) <<< FRAC_BITS;
    assign an    = num_w[DIVW-1] ? -num_w : num_w;
    assign ad    = den_w[DIVW-1] ? -den_w : den_w;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= (an << 1) + ad;
            dsor_reg <= ad << 1;
            neg_reg  <= num_w[DIVW-1] ^ den_w[DIVW-1];
        end
        else if (cmd.div_check)
        begin
            ovf_reg  <= (rem_reg >= (dsor_reg << DIV_STEPS));
            dsor_reg <= dsor_reg << (DIV_STEPS - 1);
            q_reg    <= '0;
        end
        else if (cmd.div_iter)
        begin
            if (rem_reg >= dsor_reg)
            begin
                rem_reg <= rem_reg - dsor_reg;
                q_reg   <= {q_reg[GATE_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[GATE_W-2:0], 1'b0};
            end
            dsor_reg <= dsor_reg >> 1;
        end
    end

    assign q_ext    = {1'b0, q_reg};
    assign q_signed = neg_reg ? -q_ext : q_ext;

    always_comb
    begin
        if (ovf_reg)
        begin
            div_value = neg_reg ? GATE_MIN : GATE_MAX;
        end
        else if (q_signed > Q_HI)
        begin
            div_value = GATE_MAX;
        end
        else if (q_signed < Q_LO)
        begin
            div_value = GATE_MIN;
        end
        else
        begin
            div_value = q_signed[GATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg  <= '0;
            pw_reg <= '0;
        end
        else
        begin
            if (cmd.p_from_acc)
            begin
                p_reg <= rounded;
            end
            else if (cmd.p_from_div)
            begin
                p_reg <= div_value;
            end
            if (cmd.pw_from_r)
            begin
                pw_reg <= r_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_from_acc || cmd.r_from_prod)
        begin
            r_reg <= rounded;
        end
        else if (cmd.p_from_div)
        begin
            r_reg <= div_value;
        end
    end

    // output register
    gate_t out_state_reg;
    gate_t out_pow_reg;
    logic  out_err_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_state_reg <= p_reg;
            out_pow_reg   <= pw_reg;
            out_err_reg   <= cmd.out_err;
        end
    end

    assign gate_state  = out_state_reg;
    assign gate_output = out_pow_reg;
    assign error       = out_err_reg;

    // status
    always_comb
    begin
        stat.mode     = mode_reg;
        stat.write_ok = (32'(ei_reg) < 32'(TABLE_DEPTH));
        stat.range_ok = !vdiff[VOLT_W] && (TW'(vdiff[VOLT_W-1:0]) <= top);
        stat.den_zero = (den_w == '0);
        case (power_reg)
            3'd0, 3'd1: stat.pow_count = 2'd0;
            3'd2:       stat.pow_count = 2'd1;
            3'd3:       stat.pow_count = 2'd2;
            default:    stat.pow_count = 2'd3;
        endcase
    end

endmodule

@@ rtl/voltage_gate_table_step_unit.sv @@
// Voltage gate table step unit: per-bin coefficient table, gate update p = c1*p + c2,
// power output and steady-state reset. One word at a time.
// A word is accepted only once the result of the last one is in the output register, which
// waits while an earlier result has not been taken. Steps use the shared multiplier and
// steady-state resets the 18-step divider; writes and error resets use neither.
// Reset (rst_n, async): p and its power zero, config to defaults; table not cleared.
module voltage_gate_table_step_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // voltage[15:0], entry_index[23:16], entry_decay[41:24], entry_drive[59:42], zeros
    input  logic [63:0]                     s_tdata,
    // mode[1:0]
    input  logic [vgts_pkg::MODE_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // gate_state[17:0], gate_output[35:18], zeros
    output logic [39:0]                     m_tdata,
    // error[0]
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_we,
    input  logic [vgts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vgts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vgts_pkg::*;

    vgts_cmd_t cmd;
    vgts_stat_t stat;
    gate_t     gate_state;
    gate_t     gate_output;
    logic      error;

    vgts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vgts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (s_tuser),
        .voltage     (s_tdata[15:0]),
        .entry_index (s_tdata[23:16]),
        .entry_decay (s_tdata[41:24]),
        .entry_drive (s_tdata[59:42]),
        .cmd         (cmd),
        .stat        (stat),
        .gate_state  (gate_state),
        .gate_output (gate_output),
        .error       (error)
    );

    assign m_tdata = {4'b0, gate_output, gate_state};
    assign m_tuser = error;

endmodule
